[hdl/websocket_client_frame_builder_unit_assert.svh]
// Assertion macros for the frame builder. Simulation builds get concurrent
// assertions clocked on clk_i with reset rst_ni; synthesis builds get nothing.
`ifndef WEBSOCKET_CLIENT_FRAME_BUILDER_UNIT_ASSERT_SVH
`define WEBSOCKET_CLIENT_FRAME_BUILDER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define WSFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WSFB_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define WSFB_ASSERT(lbl, prop, msg)
`define WSFB_ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

[hdl/wsfb_pkg.sv]
package wsfb_pkg;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_e;

  localparam logic [7:0]  HDR_FIN_BIT   = 8'h80;
  localparam logic [7:0]  HDR_MASK_BIT  = 8'h80;
  localparam logic [62:0] LEN_SHORT_MAX = 63'd125;
  localparam logic [62:0] LEN_MID_MAX   = 63'd65535;
  localparam logic [6:0]  LEN_CODE_16   = 7'd126;
  localparam logic [6:0]  LEN_CODE_64   = 7'd127;
  localparam logic [3:0]  EXT_NONE      = 4'd0;
  localparam logic [3:0]  EXT_16        = 4'd2;
  localparam logic [3:0]  EXT_64        = 4'd8;
  // First byte, length byte and four mask bytes, minus one for the last index.
  localparam logic [3:0]  HDR_BASE_LAST = 4'd5;

  typedef struct packed {
    op_e         op;
    logic [3:0]  opcode;
    logic [62:0] payload_length;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       frame_end;
    logic       stray_error;
  } res_t;

  typedef struct packed {
    logic frame_open;
    logic hdr_busy;
  } emit_stat_t;

endpackage

[hdl/wsfb_in_stage.sv]
module wsfb_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  wsfb_pkg::item_t item_i,
  input  logic            take_i,
  output logic            item_valid_o,
  output wsfb_pkg::item_t item_o
);
  import wsfb_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // The held word leaves when the emitter consumes it, so a new one can land
  // in the same cycle.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[hdl/wsfb_emit.sv]
module wsfb_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  wsfb_pkg::item_t      item_i,
  input  logic                 out_ready_i,
  output logic                 take_o,
  output logic                 res_valid_o,
  output wsfb_pkg::res_t       res_o,
  output wsfb_pkg::emit_stat_t stat_o
);
  import wsfb_pkg::*;

  logic [3:0]  idx_q, idx_d;
  logic [62:0] bytes_left_q, bytes_left_d;
  logic [1:0]  mask_phase_q, mask_phase_d;
  logic [31:0] held_mask_q, held_mask_d;
  logic        frame_open_q, frame_open_d;

  logic        advance;
  logic        is_short, is_mid;
  logic [3:0]  ext_n, last_idx, len_pos, key_pos;
  logic [6:0]  len_code;
  logic [63:0] len64;
  logic        at_last, len_zero, last_payload;
  res_t        res;

  assign advance      = item_valid_i && out_ready_i;
  assign is_short     = item_i.payload_length <= LEN_SHORT_MAX;
  assign is_mid       = item_i.payload_length <= LEN_MID_MAX;
  assign len_zero     = item_i.payload_length == '0;
  assign len64        = {1'b0, item_i.payload_length};
  assign last_payload = bytes_left_q == 63'd1;

  always_comb begin
    priority if (is_short) begin
      ext_n    = EXT_NONE;
      len_code = item_i.payload_length[6:0];
    end else if (is_mid) begin
      ext_n    = EXT_16;
      len_code = LEN_CODE_16;
    end else begin
      ext_n    = EXT_64;
      len_code = LEN_CODE_64;
    end
  end

  assign last_idx = HDR_BASE_LAST + ext_n;
  assign at_last  = idx_q == last_idx;
  // Extended length goes out most significant byte first, the key low byte first.
  assign len_pos  = ext_n + 4'd1 - idx_q;
  assign key_pos  = idx_q - 4'd2 - ext_n;

  always_comb begin
    res    = '0;
    take_o = 1'b0;
    unique case (item_i.op)
      OP_START: begin
        res.is_header = 1'b1;
        take_o        = advance && at_last;
        if (idx_q == 4'd0) begin
          res.out_byte = HDR_FIN_BIT | {4'b0000, item_i.opcode};
        end else if (idx_q == 4'd1) begin
          res.out_byte = HDR_MASK_BIT | {1'b0, len_code};
        end else if (idx_q < 4'd2 + ext_n) begin
          res.out_byte = len64[{len_pos[2:0], 3'b000} +: 8];
        end else begin
          res.out_byte  = item_i.mask_key[{key_pos[1:0], 3'b000} +: 8];
          res.frame_end = at_last && len_zero;
        end
      end
      OP_PAYLOAD: begin
        take_o = advance;
        if (!frame_open_q) begin
          res.stray_error = 1'b1;
        end else begin
          res.out_byte  = item_i.payload_byte ^ held_mask_q[{mask_phase_q, 3'b000} +: 8];
          res.frame_end = last_payload;
        end
      end
      default: begin
        take_o = advance;
      end
    endcase
  end

  always_comb begin
    idx_d        = idx_q;
    bytes_left_d = bytes_left_q;
    mask_phase_d = mask_phase_q;
    held_mask_d  = held_mask_q;
    frame_open_d = frame_open_q;
    if (advance && item_i.op == OP_START) begin
      idx_d = at_last ? 4'd0 : idx_q + 4'd1;
      if (at_last) begin
        held_mask_d  = item_i.mask_key;
        mask_phase_d = 2'd0;
        bytes_left_d = item_i.payload_length;
        frame_open_d = !len_zero;
      end
    end else if (advance && frame_open_q) begin
      bytes_left_d = bytes_left_q - 63'd1;
      mask_phase_d = mask_phase_q + 2'd1;
      if (last_payload) begin
        frame_open_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      bytes_left_q <= '0;
      mask_phase_q <= '0;
      held_mask_q  <= '0;
      frame_open_q <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      bytes_left_q <= bytes_left_d;
      mask_phase_q <= mask_phase_d;
      held_mask_q  <= held_mask_d;
      frame_open_q <= frame_open_d;
    end
  end

  assign res_valid_o       = item_valid_i;
  assign res_o             = res;
  assign stat_o.frame_open = frame_open_q;
  assign stat_o.hdr_busy   = idx_q != 4'd0;

endmodule

[hdl/wsfb_out_stage.sv]
module wsfb_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  wsfb_pkg::res_t res_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wsfb_pkg::res_t res_o
);
  import wsfb_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;
  logic load;

  assign ready_o = !valid_q || !out_stall_i;
  assign load    = res_valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[hdl/websocket_client_frame_builder_unit.sv]
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_stall_o   op, opcode, payload_length, mask_key, payload_byte
// out      output     out_valid_o / out_stall_i out_byte, is_header, frame_end, stray_error
//
// Payload bytes stream out one per cycle while the output is not stalled.
// A start word sends 6, 8 or 14 header bytes (7-bit, 16-bit or 64-bit length form),
// counted by the header byte counter that sends one wire byte per cycle unless stalled.
// The first wire byte of an accepted word is loaded into the output register while it is not stalled.
// Reset is asynchronous and active low; it closes any open frame.
// A stall on the output holds the output register and backs up into the input.
module websocket_client_frame_builder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [3:0]  opcode_i,
  input  logic [62:0] payload_length_i,
  input  logic [31:0] mask_key_i,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        is_header_o,
  output logic        frame_end_o,
  output logic        stray_error_o
);
  import wsfb_pkg::*;

  `include "websocket_client_frame_builder_unit_assert.svh"

  item_t      in_item, cur_item;
  logic       cur_valid, take, out_ready, res_valid;
  res_t       res, out_res;
  emit_stat_t stat;

  // Incoming word as one struct; op is carried as its enum code.
  assign in_item.op             = op_e'(op_i);
  assign in_item.opcode         = opcode_i;
  assign in_item.payload_length = payload_length_i;
  assign in_item.mask_key       = mask_key_i;
  assign in_item.payload_byte   = payload_byte_i;

  // The input register holds the word being worked on. A start word stays
  // there while its header bytes go out, which keeps its fields at hand for
  // the byte selection without a second copy.
  wsfb_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .take_i       (take),
    .item_valid_o (cur_valid),
    .item_o       (cur_item)
  );

  // The emitter picks the next wire byte and owns the frame state: remaining
  // byte count, mask phase, held key and whether a frame is open.
  wsfb_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (cur_valid),
    .item_i       (cur_item),
    .out_ready_i  (out_ready),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .stat_o       (stat)
  );

  // The output register separates the downstream stall from the frame logic
  // as far as valid goes; it refills in the same cycle it drains.
  wsfb_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign out_byte_o    = out_res.out_byte;
  assign is_header_o   = out_res.is_header;
  assign frame_end_o   = out_res.frame_end;
  assign stray_error_o = out_res.stray_error;

  // A header byte is never also a stray-byte error.
  `WSFB_ASSERT_NEVER(a_hdr_not_stray, out_valid_o && is_header_o && stray_error_o, "header byte flagged as stray")

  // A stray byte carries a zero byte and does not end a frame.
  `WSFB_ASSERT(a_stray_clean, out_valid_o && stray_error_o |-> out_byte_o == 8'h00 && !frame_end_o, "stray byte has data or frame end")

  // After the last byte of a frame goes out, no frame is left open.
  `WSFB_ASSERT(a_end_closes, take && res.frame_end |=> !stat.frame_open, "frame still open after its last byte")

  // The header counter only runs while a start word is held.
  `WSFB_ASSERT(a_hdr_needs_start, stat.hdr_busy |-> cur_valid && cur_item.op == OP_START, "header counter running without a start word")

endmodule
